[hw/rtl/mar_pkg.sv]
// ----------------------------------------------------------------------------
// mar_pkg
// Shared types, codes and constants of the mount axis rate manager.
// ----------------------------------------------------------------------------
package mar_pkg;

  localparam int AXES          = 2;
  localparam int POS_BITS      = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [9:0]  RST_RAMP_STEP      = 10'd200;
  localparam logic [7:0]  RST_IDLE_LIMIT     = 8'd100;
  localparam logic [2:0]  RST_TRIM_PERIOD    = 3'd6;
  localparam logic [11:0] RST_MIN_GOTO_SPEED = 12'd20;
  localparam logic [11:0] RST_MAX_SPEED      = 12'd4000;
  localparam logic [11:0] RST_RAMP_THRESHOLD = 12'd1600;
  localparam logic [5:0]  RST_GUIDE_LIMIT    = 6'd5;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_TRACK = 2'd1,
    CMD_SLEW  = 2'd2,
    CMD_GOTO  = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    K_OFF  = 3'd0,
    K_ON   = 3'd1,
    K_SLEW = 3'd2,
    K_GOTO = 3'd3,
    K_DONE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CFG_RAMP_STEP      = 3'd0,
    CFG_IDLE_LIMIT     = 3'd1,
    CFG_TRIM_PERIOD    = 3'd2,
    CFG_MIN_GOTO_SPEED = 3'd3,
    CFG_MAX_SPEED      = 3'd4,
    CFG_RAMP_THRESHOLD = 3'd5,
    CFG_GUIDE_LIMIT    = 3'd6
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_T_CHECK,
    ST_T_START,
    ST_T_WAIT,
    ST_T_AXIS,
    ST_T_OFF,
    ST_R_ON,
    ST_R_ACT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_T_AXIS,
    STEP_T_OFF,
    STEP_R_ON,
    STEP_R_ACT,
    STEP_DONE
  } step_t;

  typedef struct packed {
    command_t           command;
    logic               axis;
    logic signed [15:0] rate;
    logic [23:0]        target;
    logic               ra_disabled;
    logic               ra_idle;
    logic signed [23:0] ra_position;
    logic               dec_disabled;
    logic               dec_idle;
    logic signed [23:0] dec_position;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic        out_axis;
    logic        direction;
    logic [11:0] speed;
    logic [23:0] goto_position;
    logic        ok;
    logic        last;
  } res_t;

  typedef struct packed {
    logic  load;
    logic  fire;
    step_t step;
    logic  tick_ax;
    logic  dist_load;
    logic  root_start;
  } mar_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic need_root;
    logic root_busy;
    logic slot_free;
  } mar_status_t;

endpackage

[hw/rtl/mar_if.sv]
// ----------------------------------------------------------------------------
// mar_if
// Request and result channels of the mount axis rate manager.
// ----------------------------------------------------------------------------
interface mar_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               axis;
  logic signed [15:0] rate;
  logic [23:0]        target;
  logic               ra_disabled;
  logic               ra_idle;
  logic signed [23:0] ra_position;
  logic               dec_disabled;
  logic               dec_idle;
  logic signed [23:0] dec_position;

  modport source (
    output valid, command, axis, rate, target, ra_disabled, ra_idle, ra_position,
           dec_disabled, dec_idle, dec_position,
    input  ready
  );
  modport sink (
    input  valid, command, axis, rate, target, ra_disabled, ra_idle, ra_position,
           dec_disabled, dec_idle, dec_position,
    output ready
  );
endinterface

interface mar_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        out_axis;
  logic        direction;
  logic [11:0] speed;
  logic [23:0] goto_position;
  logic        ok;
  logic        last;

  modport source (
    output valid, kind, out_axis, direction, speed, goto_position, ok, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_axis, direction, speed, goto_position, ok, last,
    output ready
  );
endinterface

[hw/rtl/mar_root.sv]
// ----------------------------------------------------------------------------
// mar_root
// Bit-serial rounded integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mar_root #(
  parameter int XW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [XW-1:0]   x,
  output logic            busy,
  output logic [XW/2:0]   root
);

  logic [XW-1:0] rem;
  logic [XW-1:0] r;
  logic [XW-1:0] bitpos;
  logic [XW:0]   trial;

  assign busy  = |bitpos;
  assign trial = {1'b0, r} + {1'b0, bitpos};

  always_ff @(posedge clk) begin
    if (rst) begin
      bitpos <= '0;
    end else if (start) begin
      rem    <= x;
      r      <= '0;
      bitpos <= {2'b01, {(XW-2){1'b0}}};
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[XW-1:0];
        r   <= (r >> 1) + bitpos;
      end else begin
        r <= r >> 1;
      end
      bitpos <= bitpos >> 2;
    end
  end

  // round up when the remainder passes the floor root
  assign root = r[XW/2:0] + (XW/2+1)'(rem > r);

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("root unit not busy after start");
`endif

endmodule

[hw/rtl/mar_dp.sv]
// ----------------------------------------------------------------------------
// mar_dp
// Datapath: configuration, per-axis rate state, step logic, result register.
// ----------------------------------------------------------------------------
module mar_dp #(
  parameter int POS_BITS = mar_pkg::POS_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [mar_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [mar_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  mar_pkg::req_t                         req,
  input  mar_pkg::mar_cmd_t                     cm,
  output mar_pkg::mar_status_t                  st,
  output mar_pkg::res_t                         res_q,
  output logic                                  result_valid,
  input  logic                                  result_ready
);

  localparam int W  = (POS_BITS > 24) ? POS_BITS : 24;
  localparam int DW = W + 1;
  localparam int XW = ((DW + 8) / 2) * 2;
  localparam int RW = XW / 2 + 1;

  function automatic mar_pkg::res_t slew_item(input logic ax,
                                              input logic signed [18:0] r,
                                              input logic [11:0] lim);
    logic [18:0]   m;
    mar_pkg::res_t it;
    m = r[18] ? 19'(-r) : 19'(r);
    it = '0;
    it.kind      = mar_pkg::K_SLEW;
    it.out_axis  = ax;
    it.direction = !r[18] && (r != 19'sd0);
    it.speed     = (m > {7'b0, lim}) ? lim : m[11:0];
    return it;
  endfunction

  // configuration
  logic [9:0]  ramp_step;
  logic [7:0]  idle_limit;
  logic [2:0]  trim_period;
  logic [11:0] min_goto_speed;
  logic [11:0] max_speed;
  logic [11:0] ramp_threshold;
  logic [5:0]  guide_limit;

  // state
  logic signed [17:0]  rate_now       [mar_pkg::AXES];
  logic signed [15:0]  slew_goal      [mar_pkg::AXES];
  logic                ramp_on        [mar_pkg::AXES];
  logic [15:0]         track_set      [mar_pkg::AXES];
  logic [15:0]         track_now      [mar_pkg::AXES];
  logic [POS_BITS-1:0] goto_from      [mar_pkg::AXES];
  logic [POS_BITS-1:0] goto_to        [mar_pkg::AXES];
  logic [2:0]          tick_phase;
  logic [7:0]          idle_count;
  logic                ok;

  logic signed [17:0]  rate_now_next  [mar_pkg::AXES];
  logic signed [15:0]  slew_goal_next [mar_pkg::AXES];
  logic                ramp_on_next   [mar_pkg::AXES];
  logic [15:0]         track_set_next [mar_pkg::AXES];
  logic [15:0]         track_now_next [mar_pkg::AXES];
  logic [POS_BITS-1:0] goto_from_next [mar_pkg::AXES];
  logic [POS_BITS-1:0] goto_to_next   [mar_pkg::AXES];
  logic [2:0]          tick_phase_next;
  logic [7:0]          idle_count_next;
  logic                ok_next;

  mar_pkg::req_t       q;
  logic [DW-1:0]       dist_q;
  logic [XW-1:0]       root_x;
  logic [RW-1:0]       root_val;
  logic                root_busy;

  logic                sel;
  logic                dis_a;
  logic                idle_a;
  logic [23:0]         pos_a;
  logic signed [W-1:0] t_w;
  logic signed [W-1:0] f_w;
  logic signed [W-1:0] p_w;
  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] d2;
  logic [DW-1:0]       a1;
  logic [DW-1:0]       a2;
  logic [DW-1:0]       dmin;
  logic [RW-1:0]       s_low;
  logic [11:0]         goto_spd;
  logic                res_v;
  mar_pkg::res_t       res_n;

  assign sel    = (q.command == mar_pkg::CMD_TICK) ? cm.tick_ax : q.axis;
  assign dis_a  = sel ? q.dec_disabled : q.ra_disabled;
  assign idle_a = sel ? q.dec_idle : q.ra_idle;
  assign pos_a  = sel ? q.dec_position : q.ra_position;

  // distance to the nearer end of the goto
  assign t_w  = W'($signed(goto_to[sel]));
  assign f_w  = W'($signed(goto_from[sel]));
  assign p_w  = W'($signed(POS_BITS'(pos_a)));
  assign d1   = DW'(t_w) - DW'(p_w);
  assign d2   = DW'(p_w) - DW'(f_w);
  assign a1   = d1[DW-1] ? DW'(-d1) : DW'(d1);
  assign a2   = d2[DW-1] ? DW'(-d2) : DW'(d2);
  assign dmin = (a1 < a2) ? a1 : a2;

  // 100 * d as shifts
  assign root_x = (XW'(dist_q) << 6) + (XW'(dist_q) << 5) + (XW'(dist_q) << 2);

  mar_root #(.XW(XW)) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (cm.root_start),
    .x     (root_x),
    .busy  (root_busy),
    .root  (root_val)
  );

  assign s_low    = (root_val < RW'(min_goto_speed)) ? RW'(min_goto_speed) : root_val;
  assign goto_spd = (s_low > RW'(max_speed)) ? max_speed : s_low[11:0];

  assign st.is_tick   = (q.command == mar_pkg::CMD_TICK);
  assign st.need_root = !dis_a && !idle_a && (goto_to[sel] != goto_from[sel]);
  assign st.root_busy = root_busy;
  assign st.slot_free = !result_valid || result_ready;

  always_comb begin
    logic signed [18:0] rn19;
    logic signed [18:0] g19;
    logic signed [18:0] rate19;
    logic signed [18:0] gl19;
    logic signed [18:0] th19;
    logic signed [18:0] mx19;
    logic signed [18:0] st19;
    logic signed [18:0] rr;
    logic signed [18:0] nr;
    logic signed [18:0] goal;
    logic [15:0]        nt;
    logic [16:0]        mag;
    logic [2:0]         per;
    logic [POS_BITS-1:0] tgt;

    rate_now_next   = rate_now;
    slew_goal_next  = slew_goal;
    ramp_on_next    = ramp_on;
    track_set_next  = track_set;
    track_now_next  = track_now;
    goto_from_next  = goto_from;
    goto_to_next    = goto_to;
    tick_phase_next = tick_phase;
    idle_count_next = idle_count;
    ok_next         = ok;
    res_v           = 1'b0;
    res_n           = '0;

    rn19   = 19'(rate_now[sel]);
    g19    = 19'(slew_goal[sel]);
    rate19 = 19'(q.rate);
    gl19   = $signed({13'b0, guide_limit});
    th19   = $signed({7'b0, ramp_threshold});
    mx19   = $signed({7'b0, max_speed});
    st19   = $signed({9'b0, ramp_step});
    mag    = q.rate[15] ? 17'(-17'(q.rate)) : 17'(q.rate);
    per    = (trim_period == 3'd0) ? 3'd1 : trim_period;
    tgt    = POS_BITS'(q.target);
    rr     = rn19;
    nr     = '0;
    goal   = rate19;
    nt     = track_set[0];

    if (cm.load) begin
      ok_next = 1'b0;
    end

    if (cm.fire) begin
      unique case (cm.step)
        mar_pkg::STEP_T_AXIS: begin
          if (dis_a) begin
            rate_now_next[sel] = '0;
          end else if (!idle_a) begin
            if (goto_to[sel] != goto_from[sel]) begin
              res_v               = 1'b1;
              res_n.kind          = mar_pkg::K_GOTO;
              res_n.out_axis      = sel;
              res_n.speed         = goto_spd;
              res_n.goto_position = 24'(goto_to[sel]);
            end
          end else if (ramp_on[sel]) begin
            if (rn19 < g19) begin
              rr = rn19 + st19;
              if (rr > g19) rr = g19;
            end else if (rn19 > g19) begin
              rr = rn19 - st19;
              if (rr < g19) rr = g19;
            end
            ramp_on_next[sel] = (rr != g19);
            if (rr != rn19) begin
              rate_now_next[sel] = rr[17:0];
              res_v = 1'b1;
              res_n = slew_item(sel, rr, max_speed);
            end
          end else if (!sel && track_set[0] != 16'd0) begin
            // tracking trim and guiding on right ascension
            nt = (tick_phase == 3'd0) ? track_set[0] - 16'd1 : track_set[0];
            track_now_next[0] = nt;
            if (g19 > -gl19 && g19 < gl19) begin
              nr = $signed({3'b0, nt}) + g19;
              if (nr < 0) nr = '0;
              if (rn19 != nr) begin
                rate_now_next[0] = nr[17:0];
                res_v = 1'b1;
                res_n = slew_item(1'b0, nr, max_speed);
              end
            end
          end
        end
        mar_pkg::STEP_T_OFF: begin
          if (!q.ra_disabled && q.ra_idle && !q.dec_disabled && q.dec_idle &&
              rate_now[0] == 18'sd0 && rate_now[1] == 18'sd0) begin
            if (idle_count >= idle_limit) begin
              res_v      = 1'b1;
              res_n.kind = mar_pkg::K_OFF;
            end
            if (idle_count != 8'hFF) idle_count_next = idle_count + 8'd1;
          end else begin
            idle_count_next = '0;
          end
          tick_phase_next = ({1'b0, tick_phase} + 4'd1 >= {1'b0, per}) ? 3'd0
                                                                      : tick_phase + 3'd1;
          ok_next = 1'b1;
        end
        mar_pkg::STEP_R_ON: begin
          unique case (q.command)
            mar_pkg::CMD_TRACK: res_v = dis_a && (mag != 17'd0);
            mar_pkg::CMD_SLEW:  res_v = dis_a && !(q.rate == 16'sd0 && track_set[sel] == 16'd0);
            mar_pkg::CMD_GOTO:  res_v = dis_a;
            default:            res_v = 1'b0;
          endcase
          res_n.kind = mar_pkg::K_ON;
        end
        mar_pkg::STEP_R_ACT: begin
          unique case (q.command)
            mar_pkg::CMD_TRACK: begin
              if (dis_a && mag == 17'd0) begin
                ok_next = 1'b1;
              end else if (idle_a && !ramp_on[sel] && slew_goal[sel] == 16'sd0) begin
                rate_now_next[sel] = 18'(mag);
                res_v   = 1'b1;
                res_n   = slew_item(sel, $signed({2'b0, mag}), max_speed);
                ok_next = 1'b1;
              end
              track_set_next[sel] = mag[15:0];
              track_now_next[sel] = mag[15:0];
            end
            mar_pkg::CMD_SLEW: begin
              if (dis_a && q.rate == 16'sd0 && track_set[sel] == 16'd0) begin
                ok_next = 1'b1;
              end else if (!idle_a) begin
                ok_next = ok;
              end else if (track_set[sel] == 16'd0 || ramp_on[sel] ||
                           rate19 > gl19 || rate19 < -gl19) begin
                ok_next = 1'b1;
                if (rate19 <= -th19) begin
                  goal = -mx19;
                  ramp_on_next[sel] = 1'b1;
                end else if (rate19 >= th19) begin
                  goal = mx19;
                  ramp_on_next[sel] = 1'b1;
                end else if (!ramp_on[sel] && rn19 > -th19 && rn19 < th19) begin
                  rate_now_next[sel] = rate19[17:0];
                  res_v = 1'b1;
                  res_n = slew_item(sel, rate19, max_speed);
                end else begin
                  ramp_on_next[sel] = 1'b1;
                end
              end else begin
                // guiding pulse on top of tracking
                nr = $signed({3'b0, track_now[sel]}) + rate19;
                if (nr < 0) nr = '0;
                rate_now_next[sel] = nr[17:0];
                res_v   = 1'b1;
                res_n   = slew_item(sel, nr, max_speed);
                ok_next = 1'b1;
              end
              slew_goal_next[sel] = goal[15:0];
            end
            mar_pkg::CMD_GOTO: begin
              if (idle_a) begin
                goto_from_next[sel] = POS_BITS'(pos_a);
                goto_to_next[sel]   = tgt;
                rate_now_next[sel]  = '0;
                res_v               = 1'b1;
                res_n.kind          = mar_pkg::K_GOTO;
                res_n.out_axis      = sel;
                res_n.speed         = (min_goto_speed > max_speed) ? max_speed
                                                                   : min_goto_speed;
                res_n.goto_position = 24'(tgt);
              end
              ok_next = 1'b1;
            end
            default: ok_next = ok;
          endcase
        end
        mar_pkg::STEP_DONE: begin
          res_v      = 1'b1;
          res_n.kind = mar_pkg::K_DONE;
          res_n.ok   = ok;
          res_n.last = 1'b1;
        end
        default: res_v = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step      <= mar_pkg::RST_RAMP_STEP;
      idle_limit     <= mar_pkg::RST_IDLE_LIMIT;
      trim_period    <= mar_pkg::RST_TRIM_PERIOD;
      min_goto_speed <= mar_pkg::RST_MIN_GOTO_SPEED;
      max_speed      <= mar_pkg::RST_MAX_SPEED;
      ramp_threshold <= mar_pkg::RST_RAMP_THRESHOLD;
      guide_limit    <= mar_pkg::RST_GUIDE_LIMIT;
      for (int i = 0; i < mar_pkg::AXES; i++) begin
        rate_now[i]  <= '0;
        slew_goal[i] <= '0;
        ramp_on[i]   <= 1'b0;
        track_set[i] <= '0;
        track_now[i] <= '0;
        goto_from[i] <= '0;
        goto_to[i]   <= '0;
      end
      tick_phase   <= '0;
      idle_count   <= '0;
      ok           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          mar_pkg::CFG_RAMP_STEP:      ramp_step      <= cfg_data[9:0];
          mar_pkg::CFG_IDLE_LIMIT:     idle_limit     <= cfg_data[7:0];
          mar_pkg::CFG_TRIM_PERIOD:    trim_period    <= cfg_data[2:0];
          mar_pkg::CFG_MIN_GOTO_SPEED: min_goto_speed <= cfg_data;
          mar_pkg::CFG_MAX_SPEED:      max_speed      <= cfg_data;
          mar_pkg::CFG_RAMP_THRESHOLD: ramp_threshold <= cfg_data;
          mar_pkg::CFG_GUIDE_LIMIT:    guide_limit    <= cfg_data[5:0];
          default: ;
        endcase
      end
      rate_now   <= rate_now_next;
      slew_goal  <= slew_goal_next;
      ramp_on    <= ramp_on_next;
      track_set  <= track_set_next;
      track_now  <= track_now_next;
      goto_from  <= goto_from_next;
      goto_to    <= goto_to_next;
      tick_phase <= tick_phase_next;
      idle_count <= idle_count_next;
      ok         <= ok_next;
      if (cm.fire && res_v) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cm.load) q <= req;
    if (cm.dist_load) dist_q <= dmin;
    if (cm.fire && res_v) res_q <= res_n;
  end

`ifndef SYNTHESIS
  a_valid_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cm.fire))
    else $error("result appeared without a step");
`endif

endmodule

[hw/rtl/mar_ctrl.sv]
// ----------------------------------------------------------------------------
// mar_ctrl
// Sequencer: walks one request or tick through its steps.
// ----------------------------------------------------------------------------
module mar_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  output logic                 request_ready,
  input  mar_pkg::mar_status_t st,
  output mar_pkg::mar_cmd_t    cm
);

  mar_pkg::state_t state;
  mar_pkg::state_t state_next;
  logic            tick_ax;
  logic            tick_ax_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mar_pkg::ST_IDLE;
      tick_ax <= 1'b0;
    end else begin
      state   <= state_next;
      tick_ax <= tick_ax_next;
    end
  end

  always_comb begin
    state_next    = state;
    tick_ax_next  = tick_ax;
    request_ready = 1'b0;
    cm            = '0;
    cm.tick_ax    = tick_ax;
    unique case (state)
      mar_pkg::ST_IDLE: begin
        request_ready = 1'b1;
        if (request_valid) begin
          cm.load    = 1'b1;
          state_next = mar_pkg::ST_START;
        end
      end
      mar_pkg::ST_START: begin
        tick_ax_next = 1'b0;
        state_next   = st.is_tick ? mar_pkg::ST_T_CHECK : mar_pkg::ST_R_ON;
      end
      mar_pkg::ST_T_CHECK: begin
        if (st.need_root) begin
          cm.dist_load = 1'b1;
          state_next   = mar_pkg::ST_T_START;
        end else begin
          state_next = mar_pkg::ST_T_AXIS;
        end
      end
      mar_pkg::ST_T_START: begin
        cm.root_start = 1'b1;
        state_next    = mar_pkg::ST_T_WAIT;
      end
      mar_pkg::ST_T_WAIT: begin
        if (!st.root_busy) state_next = mar_pkg::ST_T_AXIS;
      end
      mar_pkg::ST_T_AXIS: begin
        if (st.slot_free) begin
          cm.fire = 1'b1;
          cm.step = mar_pkg::STEP_T_AXIS;
          if (!tick_ax) begin
            tick_ax_next = 1'b1;
            state_next   = mar_pkg::ST_T_CHECK;
          end else begin
            state_next = mar_pkg::ST_T_OFF;
          end
        end
      end
      mar_pkg::ST_T_OFF: begin
        if (st.slot_free) begin
          cm.fire    = 1'b1;
          cm.step    = mar_pkg::STEP_T_OFF;
          state_next = mar_pkg::ST_DONE;
        end
      end
      mar_pkg::ST_R_ON: begin
        if (st.slot_free) begin
          cm.fire    = 1'b1;
          cm.step    = mar_pkg::STEP_R_ON;
          state_next = mar_pkg::ST_R_ACT;
        end
      end
      mar_pkg::ST_R_ACT: begin
        if (st.slot_free) begin
          cm.fire    = 1'b1;
          cm.step    = mar_pkg::STEP_R_ACT;
          state_next = mar_pkg::ST_DONE;
        end
      end
      mar_pkg::ST_DONE: begin
        if (st.slot_free) begin
          cm.fire    = 1'b1;
          cm.step    = mar_pkg::STEP_DONE;
          state_next = mar_pkg::ST_IDLE;
        end
      end
      default: state_next = mar_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_fire_free: assert property (@(posedge clk) disable iff (rst)
    cm.fire |-> st.slot_free)
    else $error("step taken while result register is blocked");
`endif

endmodule

[hw/rtl/mount_axis_rate_manager_core.sv]
// ----------------------------------------------------------------------------
// mount_axis_rate_manager_core
// Two-axis mount rate manager: ticks and requests in, motor commands out.
// ----------------------------------------------------------------------------
// A request runs ST_START, ST_R_ON and ST_R_ACT, and ST_DONE loads its done item.
// A tick runs ST_T_CHECK and ST_T_AXIS per axis, then ST_T_OFF and ST_DONE; each
// axis in goto mode adds the distance load, ST_T_START and ST_T_WAIT on the root
// unit. Steps that fire stall while the result register is blocked. One item is
// handled at a time; the next transfer is taken the cycle after the done item is
// loaded. Synchronous reset loads the register defaults and clears all axis state.
module mount_axis_rate_manager_core #(
  parameter int POS_BITS = mar_pkg::POS_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mar_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mar_pkg::CFG_DATA_BITS-1:0] cfg_data,
  mar_req_if.sink                           request,
  mar_res_if.source                         result
);

  mar_pkg::req_t        req;
  mar_pkg::res_t        res_q;
  mar_pkg::mar_cmd_t    cm;
  mar_pkg::mar_status_t st;

  assign req.command      = mar_pkg::command_t'(request.command);
  assign req.axis         = request.axis;
  assign req.rate         = request.rate;
  assign req.target       = request.target;
  assign req.ra_disabled  = request.ra_disabled;
  assign req.ra_idle      = request.ra_idle;
  assign req.ra_position  = request.ra_position;
  assign req.dec_disabled = request.dec_disabled;
  assign req.dec_idle     = request.dec_idle;
  assign req.dec_position = request.dec_position;

  mar_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request.valid),
    .request_ready (request.ready),
    .st            (st),
    .cm            (cm)
  );

  mar_dp #(.POS_BITS(POS_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req          (req),
    .cm           (cm),
    .st           (st),
    .res_q        (res_q),
    .result_valid (result.valid),
    .result_ready (result.ready)
  );

  assign result.kind          = res_q.kind;
  assign result.out_axis      = res_q.out_axis;
  assign result.direction     = res_q.direction;
  assign result.speed         = res_q.speed;
  assign result.goto_position = res_q.goto_position;
  assign result.ok            = res_q.ok;
  assign result.last          = res_q.last;

endmodule
